FILE: rtl/multi_shape_tone_oscillator_top_assert.svh
// Assertion macros for the multi-shape tone oscillator checker.
// Included by the checker file; needs no other file.
`ifndef MULTI_SHAPE_TONE_OSCILLATOR_TOP_ASSERT_SVH
`define MULTI_SHAPE_TONE_OSCILLATOR_TOP_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define MSTO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every rising clock edge.
`define MSTO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/msto_pkg.sv
// Package for the multi-shape tone oscillator: waveform codes, register
// indexes, waveform constants and the sine table builder. No dependencies.
package msto_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 8;

    localparam int ENV_W  = 8;
    localparam int SAMP_W = 8;
    localparam int WAVE_W = 3;
    localparam int TUNE_W = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_WAVEFORM = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TUNING   = 2'd1;

    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_NOISE    = 3'd4;

    localparam logic signed [SAMP_W-1:0] RAW_MAX  = 8'sd127;
    localparam logic signed [SAMP_W-1:0] RAW_MIN  = -8'sd128;
    localparam logic signed [SAMP_W-1:0] RAW_ZERO = 8'sd0;

    localparam int RAMP_OFFSET = 127;
    localparam logic [8:0] TRI_SCALE = 9'd510;
    localparam logic [8:0] SAW_SCALE = 9'd254;
    localparam logic [6:0] NOISE_HALF_MOD = 7'd127;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // First-quadrant sine scaled by 127, built at elaboration in Q30 fixed point.
    function automatic logic [6:0] sine_quadrant(input int unsigned q,
                                                 input int unsigned abits);
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        n = 64'd1 << abits;
        if (q == 0) begin
            return 7'd0;
        end
        if (64'(q) >= (n >> 2)) begin
            return 7'd127;
        end
        x  = (64'(q) * TWO_PI_Q30) >> abits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return 7'((s * 64'd127) >> 30);
    endfunction

endpackage

FILE: rtl/multi_shape_tone_oscillator_top.sv
// Multi-shape tone oscillator: phase accumulator, waveform shaping and
// envelope scaling in one registered stage. Depends on msto_pkg.
//
// The block takes one sample transaction per clock and returns its scaled
// sample in the next cycle; a full output register that is not taken stalls
// the input. The rate is set by the single stage from the phase and LFSR
// registers and input data through a quarter-wave sine table of
// 2^(SINE_ADDR_BITS-2)+1 entries, waveform select and 8 by 9 bit multiply to
// the output register. Configuration writes take effect at the next sample.
module multi_shape_tone_oscillator_top #(
    parameter int PHASE_BITS     = msto_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = msto_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msto_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [msto_pkg::TUNE_W-1:0]      i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [msto_pkg::ENV_W-1:0]       s_axis_tdata,  // [7:0] envelope_amp
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [msto_pkg::SAMP_W-1:0]      m_axis_tdata   // [7:0] sample_out
);
    import msto_pkg::*;

    localparam int A      = SINE_ADDR_BITS;
    localparam int QTR    = 1 << (A - 2);
    localparam int RAMP_W = PHASE_BITS + 9;
    localparam logic [PHASE_BITS-1:0] PH_HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
    localparam logic [PHASE_BITS-1:0] PH_QTR  = PHASE_BITS'(1) << (PHASE_BITS - 2);

    logic [PHASE_BITS-1:0]    r_phase;
    logic [15:0]              r_lfsr;
    logic [WAVE_W-1:0]        r_wave;
    logic [TUNE_W-1:0]        r_tuning;
    logic                     r_out_valid;
    logic [SAMP_W-1:0]        r_out_data;

    logic                     in_fire;
    logic [PHASE_BITS-1:0]    n_phase;
    logic [15:0]              n_lfsr;
    logic [SAMP_W-1:0]        n_out_data;

    logic [6:0]               w_qtab [QTR+1];
    logic [A-1:0]             sine_k;
    logic [A-1:0]             sine_fold;
    logic [A-2:0]             sine_q;
    logic signed [SAMP_W-1:0] sine_raw;
    logic [PHASE_BITS-1:0]    tri_t;
    logic [PHASE_BITS-1:0]    tri_arg;
    logic [PHASE_BITS-1:0]    saw_t;
    logic signed [SAMP_W-1:0] tri_raw;
    logic signed [SAMP_W-1:0] saw_raw;
    logic [8:0]               nz_s1;
    logic [7:0]               nz_s2;
    logic [6:0]               nz_m127;
    logic signed [8:0]        nz_val;
    logic signed [SAMP_W-1:0] noise_raw;
    logic signed [SAMP_W-1:0] raw;
    logic signed [16:0]       prod;
    logic signed [16:0]       prod_adj;

    for (genvar g = 0; g <= QTR; g++) begin : g_qtab
        assign w_qtab[g] = sine_quadrant(g, A);
    end

    function automatic logic signed [SAMP_W-1:0] ramp(input logic [RAMP_W-1:0] a);
        logic [RAMP_W-1:0] base;
        logic [RAMP_W-1:0] d;
        base = RAMP_W'(RAMP_OFFSET) << PHASE_BITS;
        if (a >= base) begin
            d = (a - base) >> PHASE_BITS;
            if (d > RAMP_W'(RAMP_OFFSET)) begin
                return RAW_MAX;
            end
            return signed'(d[SAMP_W-1:0]);
        end
        d = (base - a) >> PHASE_BITS;
        return -signed'(d[SAMP_W-1:0]);
    endfunction

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign n_phase = r_phase + PHASE_BITS'(r_tuning);
    assign n_lfsr  = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);

    always_comb begin
        sine_k    = r_phase[PHASE_BITS-1 -: A];
        sine_fold = {1'b0, sine_k[A-2:0]};
        if (sine_fold > A'(QTR)) begin
            sine_fold = A'(2 * QTR) - sine_fold;
        end
        sine_q   = sine_fold[A-2:0];
        sine_raw = signed'({1'b0, w_qtab[sine_q]});
        if (sine_k[A-1]) begin
            sine_raw = -sine_raw;
        end
    end

    always_comb begin
        tri_t   = r_phase + PH_QTR;
        tri_arg = (tri_t <= PH_HALF) ? tri_t : (PHASE_BITS'(0) - tri_t);
        tri_raw = ramp(RAMP_W'(tri_arg) * RAMP_W'(TRI_SCALE));
        saw_t   = r_phase ^ PH_HALF;
        saw_raw = ramp(RAMP_W'(saw_t) * RAMP_W'(SAW_SCALE));
    end

    // Remainder by 254 taken as twice the remainder by 127 of the upper bits plus
    // the low bit, folded on the identity 2^7 = 1 modulo 127.
    always_comb begin
        nz_s1   = {1'b0, n_lfsr[15:8]} + {2'b0, n_lfsr[7:1]};
        nz_s2   = 8'(nz_s1[8:7]) + {1'b0, nz_s1[6:0]};
        nz_m127 = (nz_s2 >= {1'b0, NOISE_HALF_MOD}) ? 7'(nz_s2 - {1'b0, NOISE_HALF_MOD})
                                                    : nz_s2[6:0];
        nz_val    = signed'({1'b0, nz_m127, n_lfsr[0]}) - 9'sd127;
        noise_raw = (r_tuning == '0) ? RAW_MIN : nz_val[SAMP_W-1:0];
    end

    always_comb begin
        case (r_wave)
            WAVE_SINE:     raw = sine_raw;
            WAVE_SQUARE:   raw = (r_phase > PH_HALF) ? RAW_MAX : RAW_MIN;
            WAVE_TRIANGLE: raw = tri_raw;
            WAVE_SAWTOOTH: raw = saw_raw;
            WAVE_NOISE:    raw = noise_raw;
            default:       raw = RAW_ZERO;
        endcase
        prod       = signed'({1'b0, s_axis_tdata}) * raw;
        prod_adj   = prod[16] ? (prod + 17'sd255) : prod;
        n_out_data = prod_adj[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_lfsr      <= LFSR_SEED;
            r_wave      <= WAVE_SINE;
            r_tuning    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WAVEFORM: r_wave   <= i_cfg_data[WAVE_W-1:0];
                    CFG_TUNING:   r_tuning <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (in_fire) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
                if (r_wave == WAVE_NOISE) begin
                    r_lfsr <= n_lfsr;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: rtl/msto_chk.sv
// Port checker for the multi-shape tone oscillator, bound to the top level.
// Depends on multi_shape_tone_oscillator_top_assert.svh and msto_pkg.
`include "multi_shape_tone_oscillator_top_assert.svh"

module msto_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [msto_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input logic [msto_pkg::TUNE_W-1:0]      i_cfg_data,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [msto_pkg::ENV_W-1:0]       s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [msto_pkg::SAMP_W-1:0]      m_axis_tdata
);
    import msto_pkg::*;

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    `MSTO_ASSERT(a_in_gives_out, i_clk, i_rst_n, s_fire |=> m_axis_tvalid, "accepted transaction gave no result")
    `MSTO_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
    `MSTO_ASSERT(a_out_from_in, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(s_fire), "result without input")
    `MSTO_ASSERT(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind multi_shape_tone_oscillator_top msto_chk u_msto_chk (.*);
